>>> sv/sie_pkg.sv
// ============================================================================
// sie_pkg: shared definitions for the small ISA execute unit
// Opcodes, compare conditions, field widths and the program counter reset.
// ============================================================================
package sie_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned NUM_REGS  = 16;
  localparam int unsigned REG_AW    = $clog2(NUM_REGS);

  localparam logic [XLEN-1:0] PC_RESET   = 32'h0060_2000;
  localparam logic [XLEN-1:0] PC_STEP    = 32'd4;
  localparam logic [XLEN-1:0] PC_SKIP    = 32'd8;
  localparam logic [XLEN-1:0] OFF_SIGNX  = 32'hFF00_0000;
  localparam logic [XLEN-1:0] SHIFT_LIM  = 32'd32;

  // Opcodes (low byte of the instruction word)
  localparam logic [7:0] OP_JMP_REL = 8'h01;
  localparam logic [7:0] OP_JMP_REG = 8'h02;
  localparam logic [7:0] OP_MOVI    = 8'h03;
  localparam logic [7:0] OP_ADD     = 8'h05;
  localparam logic [7:0] OP_STORE   = 8'h0A;
  localparam logic [7:0] OP_ADDI    = 8'h0C;
  localparam logic [7:0] OP_SHLI    = 8'h11;
  localparam logic [7:0] OP_CMP     = 8'h1E;

  // Compare conditions (B against A, unsigned)
  localparam logic [3:0] CND_EQ    = 4'd0;
  localparam logic [3:0] CND_NE    = 4'd1;
  localparam logic [3:0] CND_LT    = 4'd2;
  localparam logic [3:0] CND_GT    = 4'd3;
  localparam logic [3:0] CND_LE    = 4'd4;
  localparam logic [3:0] CND_GE    = 4'd5;
  localparam logic [3:0] CND_BZ    = 4'd6;
  localparam logic [3:0] CND_BNZ   = 4'd7;
  localparam logic [3:0] CND_NEVER = 4'd8;

endpackage

>>> sv/sie_if.sv
// ============================================================================
// sie_if: valid/ready channels of the small ISA execute unit
// Instruction channel and result channel, each with source and sink modports.
// ============================================================================
interface sie_inst_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface sie_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_fetch_address;
  logic        store_enable;
  logic [31:0] store_address;
  logic [31:0] store_data;
  logic        halted;

  modport source (
    output valid, output next_fetch_address, output store_enable,
    output store_address, output store_data, output halted, input ready
  );
  modport sink (
    input valid, input next_fetch_address, input store_enable,
    input store_address, input store_data, input halted, output ready
  );
endinterface

>>> sv/small_isa_execute_unit_top.sv
// ============================================================================
// small_isa_execute_unit_top: execute stage of a small custom ISA
// Executes one instruction word per transfer, keeps the program counter and
// sixteen registers, and reports the next fetch address and memory writes.
// ============================================================================
//
//  Channel  | Dir | Payload                                         | Transfer
//  ---------+-----+-------------------------------------------------+----------------
//  inst_i   | in  | instruction_word                                | valid && ready
//  res_o    | out | next_fetch_address, store_enable, store_address,| valid && ready
//           |     | store_data, halted                              |
//
//  Each instruction waits in the input register, where the
//  register file (a RAM with two registered read ports) delivers its operands,
//  and is executed into the result register when the result slot frees up.
//  One instruction per cycle is sustained while res_o is not stalled.
//  A write from the previous cycle is forwarded around the RAM read.
//  Reset: pc = 0x602000, all registers read as zero through per-entry valid
//  bits, halt clear. A stalled result holds the input register.
//
module small_isa_execute_unit_top (
  input  logic    clk_i,
  input  logic    rst_ni,
  sie_inst_if.sink  inst_i,
  sie_res_if.source res_o
);
  import sie_pkg::*;

  // Input register
  logic            in_vld_q;
  logic [XLEN-1:0] word_q;
  logic            fire;
  logic            in_ready;

  // Architectural state
  logic [XLEN-1:0]     pc_q, pc_d;
  logic                halt_q, halt_d;
  logic [NUM_REGS-1:0] rvld_q;

  // Write-back and forwarding
  logic              wr_en;
  logic [REG_AW-1:0] wr_addr;
  logic [XLEN-1:0]   wr_data;
  logic              fwd_en_q;
  logic [REG_AW-1:0] fwd_addr_q;
  logic [XLEN-1:0]   fwd_data_q;

  // Operand read
  logic [REG_AW-1:0] rd_addr_a, rd_addr_b;
  logic [XLEN-1:0]   ram_a, ram_b;
  logic [XLEN-1:0]   val_a, val_b;

  // Decoded fields
  logic [7:0]        opc;
  logic [REG_AW-1:0] fld_a, fld_b;
  logic [3:0]        cnd;
  logic [XLEN-1:0]   imm, off;
  logic              cnd_hold;
  logic [XLEN-1:0]   pc_inc;

  // Result register
  logic            out_vld_q;
  logic [XLEN-1:0] nfa_q, nfa_d;
  logic            st_en_q, st_en_d;
  logic [XLEN-1:0] st_addr_q, st_addr_d;
  logic [XLEN-1:0] st_data_q, st_data_d;

  // Handshake: execute when an item waits and the result slot frees up.
  assign fire         = in_vld_q && (!out_vld_q || res_o.ready);
  assign in_ready     = !in_vld_q || fire;
  assign inst_i.ready = in_ready;

  // Operand addresses follow the incoming word, or the held one on a stall.
  assign rd_addr_a = in_ready ? inst_i.instruction_word[8 +: REG_AW]
                              : word_q[8 +: REG_AW];
  assign rd_addr_b = in_ready ? inst_i.instruction_word[12 +: REG_AW]
                              : word_q[12 +: REG_AW];

  sie_ram #(
    .WIDTH (XLEN),
    .DEPTH (NUM_REGS)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  // Field decode of the held instruction.
  assign opc   = word_q[7:0];
  assign fld_a = word_q[8 +: REG_AW];
  assign fld_b = word_q[12 +: REG_AW];
  assign cnd   = word_q[19:16];
  assign imm   = {12'd0, word_q[31:12]};
  assign off   = word_q[31] ? ({8'd0, word_q[31:8]} | OFF_SIGNX) : {8'd0, word_q[31:8]};

  // Operand values: last-cycle write first, then never-written as zero.
  always_comb begin
    if (fwd_en_q && fwd_addr_q == fld_a) begin
      val_a = fwd_data_q;
    end else if (!rvld_q[fld_a]) begin
      val_a = '0;
    end else begin
      val_a = ram_a;
    end
    if (fwd_en_q && fwd_addr_q == fld_b) begin
      val_b = fwd_data_q;
    end else if (!rvld_q[fld_b]) begin
      val_b = '0;
    end else begin
      val_b = ram_b;
    end
  end

  // Compare condition, register B against register A.
  always_comb begin
    unique case (cnd)
      CND_EQ:    cnd_hold = (val_b == val_a);
      CND_NE:    cnd_hold = (val_b != val_a);
      CND_LT:    cnd_hold = (val_b <  val_a);
      CND_GT:    cnd_hold = (val_b >  val_a);
      CND_LE:    cnd_hold = (val_b <= val_a);
      CND_GE:    cnd_hold = (val_b >= val_a);
      CND_BZ:    cnd_hold = (val_b == '0);
      CND_BNZ:   cnd_hold = (val_b != '0);
      CND_NEVER: cnd_hold = 1'b0;
      default:   cnd_hold = 1'b1;
    endcase
  end

  // Execute: next pc, register write, store and halt.
  always_comb begin
    pc_inc    = pc_q + PC_STEP;
    pc_d      = pc_inc;
    halt_d    = halt_q;
    wr_en     = 1'b0;
    wr_addr   = fld_a;
    wr_data   = '0;
    st_en_d   = 1'b0;
    st_addr_d = '0;
    st_data_d = '0;
    if (halt_q) begin
      pc_d = pc_q;
    end else begin
      unique case (opc)
        OP_JMP_REL: pc_d = pc_q + off;
        OP_JMP_REG: pc_d = pc_q + imm + val_a;
        OP_MOVI: begin
          wr_en   = 1'b1;
          wr_data = imm;
        end
        OP_ADD: begin
          wr_en   = 1'b1;
          wr_data = val_a + val_b;
        end
        OP_STORE: begin
          st_en_d   = 1'b1;
          st_addr_d = val_b;
          st_data_d = val_a;
        end
        OP_ADDI: begin
          wr_en   = 1'b1;
          wr_data = val_a + imm;
        end
        OP_SHLI: begin
          wr_en   = 1'b1;
          wr_data = (imm >= SHIFT_LIM) ? '0 : (val_a << imm[4:0]);
        end
        OP_CMP: begin
          if (cnd_hold) begin
            pc_d = pc_q + PC_SKIP;
          end
        end
        default: begin
          halt_d = 1'b1;
          pc_d   = pc_q;
        end
      endcase
    end
    wr_en = wr_en && fire;
    nfa_d = pc_d;
  end

  // Control state: handshake flags, pc, halt, register valid bits, forwarding.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pc_q      <= PC_RESET;
      halt_q    <= 1'b0;
      rvld_q    <= '0;
      fwd_en_q  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_q <= inst_i.valid;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
        pc_q      <= pc_d;
        halt_q    <= halt_d;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (wr_en) begin
        rvld_q[wr_addr] <= 1'b1;
      end
      fwd_en_q <= wr_en;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready && inst_i.valid) begin
      word_q <= inst_i.instruction_word;
    end
    fwd_addr_q <= wr_addr;
    fwd_data_q <= wr_data;
    if (fire) begin
      nfa_q     <= nfa_d;
      st_en_q   <= st_en_d;
      st_addr_q <= st_addr_d;
      st_data_q <= st_data_d;
    end
  end

  assign res_o.valid              = out_vld_q;
  assign res_o.next_fetch_address = nfa_q;
  assign res_o.store_enable       = st_en_q;
  assign res_o.store_address      = st_addr_q;
  assign res_o.store_data         = st_data_q;
  assign res_o.halted             = halt_q;

  // Halt is sticky.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared after being set");

  // While halted the program counter does not move.
  a_halt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> $stable(pc_q))
    else $error("program counter moved while halted");

  // A shown store never comes with halt.
  a_store_nohalt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && st_en_q) |-> !halt_q)
    else $error("store reported together with halt");

  // A held instruction that cannot execute blocks the input.
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !fire) |-> !inst_i.ready)
    else $error("input accepted while the input register is blocked");

endmodule

>>> sv/sie_ram.sv
// ============================================================================
// sie_ram: generic RAM, one write port and two registered read ports
// A read returns the contents from before a write in the same cycle.
// ============================================================================
module sie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
